[rtl/cos4ffc_pkg.sv]
// Package with shared types and constants for the cos^4 flat-field correction core.
`timescale 1ns / 1ps

package cos4ffc_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_IMAGE_ROWS  = 8'd0;
    localparam logic [7:0] CFG_IMAGE_COLS  = 8'd1;
    localparam logic [7:0] CFG_RADIAL_COEF = 8'd2;
    localparam logic [7:0] CFG_NORM_GAIN   = 8'd3;
    localparam logic [7:0] CFG_WIDE_MODE   = 8'd4;

    // Register reset values
    localparam logic [12:0] RST_IMAGE_ROWS  = 13'd4096;
    localparam logic [12:0] RST_IMAGE_COLS  = 13'd4096;
    localparam logic [31:0] RST_RADIAL_COEF = 32'd388000;
    localparam logic [17:0] RST_NORM_GAIN   = 18'd65536;
    localparam logic        RST_WIDE_MODE   = 1'b1;

    // Output clip levels
    localparam logic [15:0] MAX_WIDE   = 16'hFFFF;
    localparam logic [15:0] MAX_NARROW = 16'h00FF;

    // One in Q32, one half in Q16 for rounding
    localparam logic [41:0] ONE_Q32    = 42'h100_0000_0000 >> 8;
    localparam logic [55:0] ROUND_HALF = 56'h8000;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
    } t_in_item;

    typedef struct packed {
        logic [15:0] corrected_value;
        logic        saturated;
    } t_out_item;

    typedef struct packed {
        logic [12:0] image_rows;
        logic [12:0] image_cols;
        logic [31:0] radial_coef;
        logic [17:0] norm_gain;
        logic        wide_mode;
    } t_cfg;

endpackage

[rtl/cos4ffc_cfg_regs.sv]
// Configuration register file: index decode and register storage.
`timescale 1ns / 1ps

module cos4ffc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output cos4ffc_pkg::t_cfg   o_cfg
);
    import cos4ffc_pkg::*;

    t_cfg r_cfg;

    // Writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_rows  <= RST_IMAGE_ROWS;
            r_cfg.image_cols  <= RST_IMAGE_COLS;
            r_cfg.radial_coef <= RST_RADIAL_COEF;
            r_cfg.norm_gain   <= RST_NORM_GAIN;
            r_cfg.wide_mode   <= RST_WIDE_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_ROWS:  r_cfg.image_rows  <= i_cfg_data[12:0];
                CFG_IMAGE_COLS:  r_cfg.image_cols  <= i_cfg_data[12:0];
                CFG_RADIAL_COEF: r_cfg.radial_coef <= i_cfg_data;
                CFG_NORM_GAIN:   r_cfg.norm_gain   <= i_cfg_data[17:0];
                CFG_WIDE_MODE:   r_cfg.wide_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/cos4_flat_field_correction_core.sv]
// Top level of the cos^4 flat-field correction pipeline.
`timescale 1ns / 1ps

// Corrects each pixel for cos^4 lens fall-off: out = round(pixel * (1 + k*r2)^2 * norm),
// with r2 the squared distance from the frame center, clipped to 8 or 16 bits. The
// datapath is a nine-stage pipeline (offsets, r2, k*r2, gain square partial products,
// gain sum, norm products, coefficient sum, pixel products, round and clip), so one
// pixel is taken every clock while o_stall is low. A stall on the output fills empty
// stages before it reaches the input. Configuration writes are always ready, and the
// configuration must only change while no pixels are in flight.
module cos4_flat_field_correction_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // pixel input
    input  logic                    i_valid,
    output logic                    o_stall,
    input  cos4ffc_pkg::t_in_item   i_item,
    // corrected output
    output logic                    o_valid,
    input  logic                    i_stall,
    output cos4ffc_pkg::t_out_item  o_item,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [7:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    import cos4ffc_pkg::*;

    localparam int             NumStages = 9;
    localparam logic [14:0]    MaxDimW   = 15'(MAX_DIM);

    t_cfg                  w_cfg;
    logic [NumStages-1:0]  r_v;
    logic [NumStages:0]    w_rdy;

    // stage payloads
    logic [11:0] r_s0_dr, r_s0_dc;
    logic [15:0] r_s0_pix, r_s1_pix, r_s2_pix, r_s3_pix, r_s4_pix, r_s5_pix, r_s6_pix;
    logic [24:0] r_s1_r2;
    logic [56:0] r_s2_kp;
    logic [19:0] r_s3_hh;
    logic [41:0] r_s3_hl;
    logic [63:0] r_s3_ll;
    logic [51:0] r_s4_gg;
    logic [37:0] r_s5_nh;
    logic [49:0] r_s5_nl;
    logic [38:0] r_s6_cf;
    logic [22:0] r_s7_ph;
    logic [47:0] r_s7_pl;
    t_out_item   r_out_item;

    // combinational stage logic
    logic [14:0] w_rows_c, w_cols_c;
    logic [11:0] w_ctr_r, w_ctr_c;
    logic [12:0] w_dr_s, w_dc_s;
    logic [11:0] w_dr, w_dc;
    logic [41:0] w_g1;
    logic [9:0]  w_gh;
    logic [31:0] w_gl;
    logic [52:0] w_gg;
    logic [38:0] w_cf;
    logic [55:0] w_acc;
    logic [39:0] w_val;
    logic [39:0] w_maxv;
    t_out_item   n_out_item;

    cos4ffc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // Stage k may load when it is empty or its content moves on
    always_comb begin
        w_rdy[NumStages] = !i_stall;
        for (int k = NumStages - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: center (size clamped to MAX_DIM, halved) and absolute offsets
    always_comb begin
        w_rows_c = ({2'b0, w_cfg.image_rows} > MaxDimW) ? MaxDimW : {2'b0, w_cfg.image_rows};
        w_cols_c = ({2'b0, w_cfg.image_cols} > MaxDimW) ? MaxDimW : {2'b0, w_cfg.image_cols};
        w_ctr_r  = w_rows_c[12:1];
        w_ctr_c  = w_cols_c[12:1];
        w_dr_s   = {1'b0, i_item.pixel_row} - {1'b0, w_ctr_r};
        w_dc_s   = {1'b0, i_item.pixel_col} - {1'b0, w_ctr_c};
        w_dr     = w_dr_s[12] ? 12'(-w_dr_s) : w_dr_s[11:0];
        w_dc     = w_dc_s[12] ? 12'(-w_dc_s) : w_dc_s[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_dr  <= w_dr;
            r_s0_dc  <= w_dc;
            r_s0_pix <= i_item.pixel_value;
        end
    end

    // Stage 1: squared radius
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_r2  <= 25'(24'(r_s0_dr) * 24'(r_s0_dr)) + 25'(24'(r_s0_dc) * 24'(r_s0_dc));
            r_s1_pix <= r_s0_pix;
        end
    end

    // Stage 2: k * r2
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_kp  <= 57'(w_cfg.radial_coef) * 57'(r_s1_r2);
            r_s2_pix <= r_s1_pix;
        end
    end

    // Stage 3: g1 = 1 + k*r2 in Q32, partial products of its square
    always_comb begin
        w_g1 = 42'(r_s2_kp[56:16]) + ONE_Q32;
        w_gh = w_g1[41:32];
        w_gl = w_g1[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_hh  <= 20'(w_gh) * 20'(w_gh);
            r_s3_hl  <= 42'(w_gh) * 42'(w_gl);
            r_s3_ll  <= 64'(w_gl) * 64'(w_gl);
            r_s3_pix <= r_s2_pix;
        end
    end

    // Stage 4: gain gg = g1^2 in Q32
    assign w_gg = 53'({r_s3_hh, 32'b0}) + 53'({r_s3_hl, 1'b0}) + 53'(r_s3_ll[63:32]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s4_gg  <= w_gg[51:0];
            r_s4_pix <= r_s3_pix;
        end
    end

    // Stage 5: gain times norm, split at bit 32
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s5_nh  <= 38'(r_s4_gg[51:32]) * 38'(w_cfg.norm_gain);
            r_s5_nl  <= 50'(r_s4_gg[31:0]) * 50'(w_cfg.norm_gain);
            r_s5_pix <= r_s4_pix;
        end
    end

    // Stage 6: Q16 coefficient
    assign w_cf = 39'(r_s5_nh) + 39'(r_s5_nl[49:32]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_s6_cf  <= w_cf;
            r_s6_pix <= r_s5_pix;
        end
    end

    // Stage 7: pixel times coefficient, split at bit 32
    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r_s7_ph <= 23'(r_s6_pix) * 23'(r_s6_cf[38:32]);
            r_s7_pl <= 48'(r_s6_pix) * 48'(r_s6_cf[31:0]);
        end
    end

    // Stage 8: round half up, clip to mode width
    always_comb begin
        w_acc  = 56'({r_s7_ph, 32'b0}) + 56'(r_s7_pl) + ROUND_HALF;
        w_val  = w_acc[55:16];
        w_maxv = w_cfg.wide_mode ? 40'(MAX_WIDE) : 40'(MAX_NARROW);
        if (w_val > w_maxv) begin
            n_out_item.corrected_value = w_maxv[15:0];
            n_out_item.saturated       = 1'b1;
        end else begin
            n_out_item.corrected_value = w_val[15:0];
            n_out_item.saturated       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[8]) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid = r_v[NumStages-1];
    assign o_item  = r_out_item;

endmodule

[rtl/cos4ffc_checker.sv]
// Port-level checker for the correction core and its bind.
`timescale 1ns / 1ps

module cos4ffc_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_stall,
    input  logic                    o_valid,
    input  logic                    i_stall,
    input  cos4ffc_pkg::t_out_item  o_item
);
    import cos4ffc_pkg::*;

    // A clipped item always sits at one of the two clip levels
    a_sat_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.saturated) |->
            (o_item.corrected_value == MAX_WIDE || o_item.corrected_value == MAX_NARROW))
        else $error("saturated item not at a clip level");

    // Input side only stalls when the output is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled result changed");

endmodule

bind cos4_flat_field_correction_core cos4ffc_checker u_cos4ffc_checker (.*);
